/* hdl/bpstr_pkg.sv */
// ----------------------------------------------------------------------------
// bpstr_pkg
// Shared constants, codes and types of the block padding stripper.
// ----------------------------------------------------------------------------
package bpstr_pkg;

  // Largest cipher block in bytes
  localparam int BLOCK_MAX = 32;

  // Width that holds 0..BLOCK_MAX, and ring address width
  localparam int BLK_W  = $clog2(BLOCK_MAX + 1);
  localparam int ADDR_W = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
  localparam int RING_DEPTH = 2 ** ADDR_W;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Padding byte values
  localparam logic [7:0] PAD_SPACE = 8'h20;
  localparam logic [7:0] PAD_ZERO  = 8'h00;
  localparam logic [7:0] PAD_MARK  = 8'h80;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_PAD = 2'd2
  } status_t;

  // One queued command: a passed byte, or the end of a message
  typedef struct packed {
    logic              is_final;
    logic              has_pass;
    logic [7:0]        pass_byte;
    status_t           status;
    logic [ADDR_W-1:0] start;
    logic [BLK_W-1:0]  keep;
  } cmd_t;

  // Read port request from the back part
  typedef struct packed {
    logic              own;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

/* hdl/bpstr_ram.sv */
// ----------------------------------------------------------------------------
// bpstr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bpstr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read before write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/bpstr_fifo.sv */
// ----------------------------------------------------------------------------
// bpstr_fifo
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module bpstr_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  bpstr_pkg::cmd_t             push_data,
  input  logic                        pop,
  output bpstr_pkg::cmd_t             head,
  output logic                        empty,
  output logic [bpstr_pkg::QCNT_W-1:0] count
);

  bpstr_pkg::cmd_t                  entries [bpstr_pkg::QDEPTH];
  logic [bpstr_pkg::QPTR_W-1:0]     wptr;
  logic [bpstr_pkg::QPTR_W-1:0]     rptr;

  assign head  = entries[rptr];
  assign empty = (count == '0);

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + bpstr_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + bpstr_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + bpstr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - bpstr_pkg::QCNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == bpstr_pkg::QCNT_W'(bpstr_pkg::QDEPTH)))
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("command queue underflow");
`endif

endmodule

/* hdl/bpstr_front.sv */
// ----------------------------------------------------------------------------
// bpstr_front
// Accepts message bytes, keeps the hold-back ring, tracks trailing padding
// runs and issues pass and end-of-message commands into the queue.
// ----------------------------------------------------------------------------
module bpstr_front (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_we,
  input  logic [5:0]                   cfg_wdata,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,
  input  logic                         s_tlast,
  // command queue
  input  logic [bpstr_pkg::QCNT_W-1:0] q_count,
  output logic                         push,
  output bpstr_pkg::cmd_t              push_data,
  // back part
  input  logic                         drain_done,
  input  bpstr_pkg::rd_req_t           rd_req,
  // ring memory
  output logic                         ram_we,
  output logic [bpstr_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]                   ram_wdata,
  output logic [bpstr_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [7:0]                   ram_rdata
);

  localparam int BW = bpstr_pkg::BLK_W;
  localparam int AW = bpstr_pkg::ADDR_W;

  logic [5:0]    block_size;
  logic [BW-1:0] bs;
  logic [BW-1:0] held_count;
  logic [AW-1:0] block_position;
  logic [AW-1:0] wr_ptr;
  logic [BW-1:0] space_run;
  logic [BW-1:0] zero_run;
  logic          mark_before;
  logic          pending;
  logic          p1_valid;
  bpstr_pkg::cmd_t p1_cmd;

  logic          accept;
  logic          full;
  logic [AW-1:0] pass_addr;
  logic [BW-1:0] held_next;
  logic [AW-1:0] oldest_next;
  logic [BW-1:0] space_run_next;
  logic [BW-1:0] zero_run_next;
  logic          mark_before_next;
  logic          at_block_end;
  logic [BW-1:0] strip;
  bpstr_pkg::status_t st;
  logic [bpstr_pkg::QCNT_W:0] occupancy;

  // Effective block size: 0 acts as 1, large values clamp
  always_comb begin
    if (block_size == 6'd0) begin
      bs = BW'(1);
    end else if (BW'(block_size) > BW'(bpstr_pkg::BLOCK_MAX)) begin
      bs = BW'(bpstr_pkg::BLOCK_MAX);
    end else begin
      bs = BW'(block_size);
    end
  end

  // Flow control: room for this item and the one in flight
  assign occupancy = (bpstr_pkg::QCNT_W + 1)'(q_count)
                   + (bpstr_pkg::QCNT_W + 1)'(p1_valid);
  assign s_tready  = !pending
                   && (occupancy < (bpstr_pkg::QCNT_W + 1)'(bpstr_pkg::QDEPTH));
  assign accept    = s_tvalid && s_tready;

  // Ring bookkeeping
  assign full        = (held_count >= bs);
  assign pass_addr   = wr_ptr - AW'(bs);
  assign held_next   = full ? bs : held_count + BW'(1);
  assign oldest_next = wr_ptr + AW'(1) - AW'(held_next);
  assign at_block_end = ((BW'(block_position) + BW'(1)) == bs);

  // Trailing run trackers, saturating at BLOCK_MAX
  always_comb begin
    if (s_tdata == bpstr_pkg::PAD_SPACE) begin
      space_run_next = (space_run >= BW'(bpstr_pkg::BLOCK_MAX))
                     ? space_run : space_run + BW'(1);
    end else begin
      space_run_next = '0;
    end
    if (s_tdata == bpstr_pkg::PAD_ZERO) begin
      zero_run_next = (zero_run >= BW'(bpstr_pkg::BLOCK_MAX))
                    ? zero_run : zero_run + BW'(1);
      mark_before_next = mark_before;
    end else begin
      zero_run_next = '0;
      mark_before_next = (s_tdata == bpstr_pkg::PAD_MARK);
    end
  end

  // Padding decision at the final byte
  always_comb begin
    strip = '0;
    st    = bpstr_pkg::ST_OK;
    if (!at_block_end || held_next != bs) begin
      st = bpstr_pkg::ST_LEN;
    end else if (s_tdata == bpstr_pkg::PAD_SPACE) begin
      strip = (space_run_next > bs) ? bs : space_run_next;
    end else if (s_tdata == bpstr_pkg::PAD_ZERO) begin
      strip = (zero_run_next >= bs) ? bs : zero_run_next + BW'(mark_before);
    end else if (s_tdata <= 8'(bs)) begin
      strip = BW'(s_tdata);
    end else begin
      st = bpstr_pkg::ST_PAD;
    end
  end

  // Memory ports: the back part owns the read port while draining
  assign ram_we    = accept;
  assign ram_waddr = wr_ptr;
  assign ram_wdata = s_tdata;
  assign ram_raddr = rd_req.own ? rd_req.addr : pass_addr;

  // The passed byte arrives from the memory's registered read port in the cycle after acceptance
  always_comb begin
    push_data           = p1_cmd;
    push_data.pass_byte = ram_rdata;
  end
  assign push = p1_valid;

  // Command stage
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_cmd.is_final  <= s_tlast;
      p1_cmd.has_pass  <= full;
      p1_cmd.pass_byte <= 8'd0;
      p1_cmd.status    <= st;
      p1_cmd.start     <= oldest_next;
      p1_cmd.keep      <= bs - strip;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size     <= 6'd16;
      held_count     <= '0;
      block_position <= '0;
      wr_ptr         <= '0;
      space_run      <= '0;
      zero_run       <= '0;
      mark_before    <= 1'b0;
      pending        <= 1'b0;
      p1_valid       <= 1'b0;
    end else begin
      p1_valid <= accept && (full || s_tlast);
      if (drain_done) begin
        pending <= 1'b0;
      end
      if (cfg_we) begin
        block_size     <= cfg_wdata;
        held_count     <= '0;
        block_position <= '0;
        space_run      <= '0;
        zero_run       <= '0;
        mark_before    <= 1'b0;
      end else if (accept) begin
        wr_ptr <= wr_ptr + AW'(1);
        if (s_tlast) begin
          pending        <= 1'b1;
          held_count     <= '0;
          block_position <= '0;
          space_run      <= '0;
          zero_run       <= '0;
          mark_before    <= 1'b0;
        end else begin
          held_count     <= held_next;
          block_position <= at_block_end ? '0 : block_position + AW'(1);
          space_run      <= space_run_next;
          zero_run       <= zero_run_next;
          mark_before    <= mark_before_next;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= bs)
    else $error("hold-back count exceeds block size");
`endif

endmodule

/* hdl/bpstr_back.sv */
// ----------------------------------------------------------------------------
// bpstr_back
// Executes queued commands: forwards passed bytes and, at the end of a
// message, emits the status or drains the kept bytes from the ring.
// ----------------------------------------------------------------------------
module bpstr_back (
  input  logic                 clk,
  input  logic                 rst,
  // command queue
  input  bpstr_pkg::cmd_t      q_head,
  input  logic                 q_empty,
  output logic                 pop,
  // ring memory read
  output bpstr_pkg::rd_req_t   rd_req,
  input  logic [7:0]           ram_rdata,
  output logic                 drain_done,
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  output logic [2:0]           m_tuser
);

  localparam int BW = bpstr_pkg::BLK_W;
  localparam int AW = bpstr_pkg::ADDR_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FINAL = 4'b0010,
    S_ADDR  = 4'b0100,
    S_DATA  = 4'b1000
  } state_t;

  state_t state, state_next;
  bpstr_pkg::cmd_t cur, cur_next;

  logic               out_free;
  logic               load;
  logic [7:0]         ld_byte;
  logic               ld_valid;
  logic               ld_eom;
  bpstr_pkg::status_t ld_status;

  logic [7:0]         out_byte;
  logic               byte_valid;
  logic               end_of_message;
  bpstr_pkg::status_t status;

  assign out_free = !m_tvalid || m_tready;

  assign rd_req.own  = (state == S_ADDR) || (state == S_DATA);
  assign rd_req.addr = cur.start;

  // Sequencer
  always_comb begin
    state_next = state;
    cur_next   = cur;
    pop        = 1'b0;
    load       = 1'b0;
    ld_byte    = 8'd0;
    ld_valid   = 1'b0;
    ld_eom     = 1'b0;
    ld_status  = bpstr_pkg::ST_OK;
    drain_done = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          if (q_head.is_final) begin
            pop        = 1'b1;
            cur_next   = q_head;
            state_next = S_FINAL;
          end else if (out_free) begin
            pop      = 1'b1;
            load     = 1'b1;
            ld_byte  = q_head.pass_byte;
            ld_valid = 1'b1;
          end
        end
      end
      S_FINAL: begin
        if (cur.status != bpstr_pkg::ST_OK) begin
          // error: one status result, passed byte dropped
          if (out_free) begin
            load       = 1'b1;
            ld_eom     = 1'b1;
            ld_status  = cur.status;
            drain_done = 1'b1;
            state_next = S_IDLE;
          end
        end else if (cur.has_pass) begin
          if (out_free) begin
            load             = 1'b1;
            ld_byte          = cur.pass_byte;
            ld_valid         = 1'b1;
            ld_eom           = (cur.keep == '0);
            cur_next.has_pass = 1'b0;
            if (cur.keep == '0) begin
              drain_done = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_ADDR;
            end
          end
        end else if (cur.keep == '0) begin
          // everything stripped
          if (out_free) begin
            load       = 1'b1;
            ld_eom     = 1'b1;
            drain_done = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        state_next = S_DATA;
      end
      S_DATA: begin
        if (out_free) begin
          load           = 1'b1;
          ld_byte        = ram_rdata;
          ld_valid       = 1'b1;
          ld_eom         = (cur.keep == BW'(1));
          cur_next.keep  = cur.keep - BW'(1);
          cur_next.start = cur.start + AW'(1);
          if (cur.keep == BW'(1)) begin
            drain_done = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_ADDR;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and current command
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= ld_byte;
      byte_valid     <= ld_valid;
      end_of_message <= ld_eom;
      status         <= ld_status;
    end
  end

  assign m_tdata = out_byte;
  assign m_tlast = end_of_message;
  assign m_tuser = {status, byte_valid};

`ifndef NO_ASSERTIONS
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != bpstr_pkg::ST_OK) |-> (end_of_message && !byte_valid))
    else $error("error result must be a lone end-of-message item");
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADDR || state == S_DATA) |-> (cur.keep != '0))
    else $error("drain running with nothing left to emit");
`endif

endmodule

/* hdl/block_padding_stripper_core.sv */
// ----------------------------------------------------------------------------
// block_padding_stripper_core
// Strips block-cipher padding (space, zero with marker, length byte) from a
// byte stream, holding back the last block until the message ends.
// ----------------------------------------------------------------------------
// Message bytes are taken at one per cycle while the command queue has room;
// every byte that leaves the hold-back window comes out as one item. The
// window lives in a 32-entry ring memory with one registered read port. When
// the final byte arrives the input stalls until the padding is stripped and
// the kept bytes are drained: each kept byte takes an address state, then a
// registered read data state, and output back-pressure can stall the drain.
// An error gives a single item with end of message and the status; bytes
// already forwarded for that message are to be discarded by the receiver.
// A write to block_size drops the message in progress.
// ----------------------------------------------------------------------------
module block_padding_stripper_core (
  input  logic       clk,
  input  logic       rst,
  // configuration: block_size
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // final_byte
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // end_of_message
  output logic [2:0] m_axis_tuser    // [0] byte_valid, [2:1] status
);

  logic                         push;
  bpstr_pkg::cmd_t              push_data;
  logic                         pop;
  bpstr_pkg::cmd_t              q_head;
  logic                         q_empty;
  logic [bpstr_pkg::QCNT_W-1:0] q_count;
  logic                         drain_done;
  bpstr_pkg::rd_req_t           rd_req;
  logic                         ram_we;
  logic [bpstr_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                   ram_wdata;
  logic [bpstr_pkg::ADDR_W-1:0] ram_raddr;
  logic [7:0]                   ram_rdata;

  // Hold-back ring
  bpstr_ram #(
    .WIDTH (8),
    .DEPTH (bpstr_pkg::RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Front: intake and classification
  bpstr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .s_tlast    (s_axis_tlast),
    .q_count    (q_count),
    .push       (push),
    .push_data  (push_data),
    .drain_done (drain_done),
    .rd_req     (rd_req),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Command queue
  bpstr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  // Back: result generation
  bpstr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .pop        (pop),
    .rd_req     (rd_req),
    .ram_rdata  (ram_rdata),
    .drain_done (drain_done),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .m_tlast    (m_axis_tlast),
    .m_tuser    (m_axis_tuser)
  );

endmodule
